// ----- hw/rtl/bmla_pkg.sv -----
// Shared types, codes and helper functions for the byte memory access core.
package bmla_pkg;

    // Number of byte lanes, one memory bank per lane.
    localparam int NUM_LANES = 4;

    // Default capacity in bytes.
    localparam int MEM_BYTES_DEF = 4096;

    // Size register value after reset.
    localparam logic [12:0] SIZE_RESET = 13'd4096;

    // Pattern that fills every byte after reset.
    localparam logic [7:0] FILL_BYTE = 8'hA5;

    // Command codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Access size codes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Per-lane control: whether the lane takes part and which byte of the word it carries.
    typedef struct packed {
        logic       on;
        logic [1:0] pos;
    } t_lane_ctl;

    // Number of bytes moved for a size code; the unused code moves nothing.
    function automatic logic [2:0] size_count(input logic [1:0] size);
        logic [2:0] cnt;
        begin
            unique case (size)
                SIZE_BYTE: cnt = 3'd1;
                SIZE_HALF: cnt = 3'd2;
                SIZE_WORD: cnt = 3'd4;
                default:   cnt = 3'd0;
            endcase
            return cnt;
        end
    endfunction

    // Byte limit from the size register: rounded up to a multiple of 16 and capped at the capacity.
    function automatic logic [31:0] limit_of(input logic [12:0] size, input int mem_bytes);
        logic [13:0] rnd;
        logic [31:0] rnd32;
        begin
            rnd   = ({1'b0, size} + 14'd15) & ~14'h000F;
            rnd32 = 32'(rnd);
            if (rnd32 > 32'(mem_bytes)) begin
                rnd32 = 32'(mem_bytes);
            end
            return rnd32;
        end
    endfunction

endpackage

// ----- hw/rtl/bmla_lane_ram.sv -----
// Single-port byte-wide memory bank with a registered read.
module bmla_lane_ram #(
    parameter int DEPTH = bmla_pkg::MEM_BYTES_DEF / bmla_pkg::NUM_LANES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_row,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_row] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_row];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bmla_access_dec.sv -----
// Splits one access into per-lane row addresses, enables and range checks.
module bmla_access_dec #(
    parameter int MEM_BYTES = bmla_pkg::MEM_BYTES_DEF,
    parameter int ROWS      = MEM_BYTES / bmla_pkg::NUM_LANES,
    parameter int ROW_W     = $clog2(ROWS),
    parameter int LIM_W     = $clog2(MEM_BYTES + 1)
) (
    input  logic [31:0]                                   i_addr,
    input  logic [1:0]                                    i_size,
    input  logic [LIM_W-1:0]                              i_limit,
    output bmla_pkg::t_lane_ctl [bmla_pkg::NUM_LANES-1:0] o_lane,
    output logic [bmla_pkg::NUM_LANES-1:0][ROW_W-1:0]     o_row,
    output logic                                          o_bad
);

    logic [2:0]  cnt;
    logic [1:0]  pos  [bmla_pkg::NUM_LANES];
    logic [31:0] badr [bmla_pkg::NUM_LANES];
    logic [bmla_pkg::NUM_LANES-1:0] used;
    logic [bmla_pkg::NUM_LANES-1:0] legal;

    assign cnt = bmla_pkg::size_count(i_size);

    // Each lane carries the one byte of the access whose address falls in that lane.
    always_comb begin
        for (int j = 0; j < bmla_pkg::NUM_LANES; j++) begin
            pos[j]       = 2'(j) - i_addr[1:0];
            badr[j]      = i_addr + 32'(pos[j]);
            used[j]      = {1'b0, pos[j]} < cnt;
            legal[j]     = badr[j] < 32'(i_limit);
            o_lane[j].on  = used[j] & legal[j];
            o_lane[j].pos = pos[j];
            o_row[j]     = badr[j][ROW_W+1:2];
        end
    end

    assign o_bad = |(used & ~legal);

endmodule

// ----- hw/rtl/bmla_read_merge.sv -----
// Gathers lane bytes into the read word and applies sign extension.
module bmla_read_merge (
    input  logic                                          i_cmd,
    input  logic [1:0]                                    i_size,
    input  logic                                          i_sx,
    input  bmla_pkg::t_lane_ctl [bmla_pkg::NUM_LANES-1:0] i_lane,
    input  logic [bmla_pkg::NUM_LANES-1:0][7:0]           i_data,
    output logic [31:0]                                   o_rdata
);

    logic [31:0] raw;

    always_comb begin
        raw = '0;
        for (int j = 0; j < bmla_pkg::NUM_LANES; j++) begin
            if (i_lane[j].on) begin
                raw[8*i_lane[j].pos +: 8] = i_data[j];
            end
        end
        o_rdata = raw;
        if (i_sx && i_size == bmla_pkg::SIZE_BYTE && raw[7]) begin
            o_rdata = raw | 32'hFFFF_FF00;
        end else if (i_sx && i_size == bmla_pkg::SIZE_HALF && raw[15]) begin
            o_rdata = raw | 32'hFFFF_0000;
        end
        if (i_cmd == bmla_pkg::CMD_WRITE) begin
            o_rdata = '0;
        end
    end

endmodule

// ----- hw/rtl/byte_memory_le_access_core.sv -----
// Top level of the little-endian byte-addressable memory core.
//
// Input channel: i_in_valid / o_in_stall carry one access word (command, byte
// address, size, sign-extend flag, write data). Output channel: o_out_valid /
// i_out_stall return one result word per access: the read value (zero for a
// write) and a flag that is set when any byte of the access lay at or above
// the limit. Such bytes read as zero and writes to them are dropped.
// The store is split into four byte-wide banks, one per address lane, so any
// aligned or unaligned access touches each bank at most once. An access is
// registered in stage one, which drives the banks; its result is then held in
// stage two and the bank read registers, from which it is shown. The pipeline
// takes a new access every cycle while the output is not stalled and the fill
// sweep is done; the registered bank read sets the two-stage shape.
// When the receiver stalls, the whole pipeline holds, the banks are not
// enabled so their read registers keep the shown result, and o_in_stall rises.
// After reset the core writes 0xa5 into every row of the banks, with
// o_in_stall high; size register writes are taken at any time. The limit
// register resets to the value for a size of 4096.
module byte_memory_le_access_core #(
    parameter int MEM_BYTES = bmla_pkg::MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Size register write port.
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    // Access input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_addr,
    input  logic [1:0]  i_access_size,
    input  logic        i_sign_extend,
    input  logic [31:0] i_write_data,
    // Result output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_out_of_range
);

    localparam int LANES = bmla_pkg::NUM_LANES;
    localparam int ROWS  = MEM_BYTES / LANES;
    localparam int ROW_W = $clog2(ROWS);
    localparam int LIM_W = $clog2(MEM_BYTES + 1);

    // Limit in bytes, kept already rounded and capped.
    logic [LIM_W-1:0] r_limit;

    // Fill sweep after reset.
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    // Stage one: the registered access that drives the banks.
    logic        r_s1_valid;
    logic        r_s1_cmd;
    logic [31:0] r_s1_addr;
    logic [1:0]  r_s1_size;
    logic        r_s1_sx;
    logic [31:0] r_s1_wdata;

    // Stage two: the result stage, whose read bytes sit in the bank registers.
    logic                                    r_s2_valid;
    logic                                    r_s2_cmd;
    logic [1:0]                              r_s2_size;
    logic                                    r_s2_sx;
    bmla_pkg::t_lane_ctl [LANES-1:0]         r_s2_lane;
    logic                                    r_s2_bad;

    logic                               adv;
    logic                               accept;
    bmla_pkg::t_lane_ctl [LANES-1:0]    dec_lane;
    logic [LANES-1:0][ROW_W-1:0]        dec_row;
    logic                               dec_bad;
    logic [LANES-1:0]                   ram_en;
    logic [LANES-1:0]                   ram_we;
    logic [LANES-1:0][ROW_W-1:0]        ram_row;
    logic [LANES-1:0][7:0]              ram_wdata;
    logic [LANES-1:0][7:0]              ram_rdata;

    // The pipeline moves unless a shown result is held by the receiver.
    assign adv        = !(r_s2_valid && i_out_stall);
    assign o_in_stall = r_clr_busy || !adv;
    assign accept     = i_in_valid && !o_in_stall;

    bmla_access_dec #(
        .MEM_BYTES (MEM_BYTES),
        .ROWS      (ROWS),
        .ROW_W     (ROW_W),
        .LIM_W     (LIM_W)
    ) u_dec (
        .i_addr  (r_s1_addr),
        .i_size  (r_s1_size),
        .i_limit (r_limit),
        .o_lane  (dec_lane),
        .o_row   (dec_row),
        .o_bad   (dec_bad)
    );

    // Bank port selection: the fill sweep owns the banks until it is done.
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            if (r_clr_busy) begin
                ram_en[j]    = 1'b1;
                ram_we[j]    = 1'b1;
                ram_row[j]   = r_clr_row;
                ram_wdata[j] = bmla_pkg::FILL_BYTE;
            end else begin
                ram_en[j]    = adv && r_s1_valid && dec_lane[j].on;
                ram_we[j]    = r_s1_cmd == bmla_pkg::CMD_WRITE;
                ram_row[j]   = dec_row[j];
                ram_wdata[j] = r_s1_wdata[8*dec_lane[j].pos +: 8];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bmla_lane_ram #(
            .DEPTH (ROWS),
            .AW    (ROW_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (ram_en[g]),
            .i_we    (ram_we[g]),
            .i_row   (ram_row[g]),
            .i_wdata (ram_wdata[g]),
            .o_rdata (ram_rdata[g])
        );
    end

    bmla_read_merge u_merge (
        .i_cmd   (r_s2_cmd),
        .i_size  (r_s2_size),
        .i_sx    (r_s2_sx),
        .i_lane  (r_s2_lane),
        .i_data  (ram_rdata),
        .o_rdata (o_read_data)
    );

    assign o_out_valid    = r_s2_valid;
    assign o_out_of_range = r_s2_bad;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIM_W'(bmla_pkg::limit_of(bmla_pkg::SIZE_RESET, MEM_BYTES));
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= LIM_W'(bmla_pkg::limit_of(i_cfg_wdata, MEM_BYTES));
            end
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_valid <= accept;
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= i_cmd;
            r_s1_addr  <= i_addr;
            r_s1_size  <= i_access_size;
            r_s1_sx    <= i_sign_extend;
            r_s1_wdata <= i_write_data;
        end
        if (adv && r_s1_valid) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_size <= r_s1_size;
            r_s2_sx   <= r_s1_sx;
            r_s2_lane <= dec_lane;
            r_s2_bad  <= dec_bad;
        end
    end

endmodule
